// ===== hw/rtl/gcc_pkg.sv =====
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared types and constants for the FASTA GC-content counter.
// ----------------------------------------------------------------------------
package gcc_pkg;

  localparam int COUNT_WIDTH = 32;   // default width of the base and bad-byte counters
  localparam int FIELD_WIDTH = 32;   // width of the total fields in a result
  localparam int WIDE_WIDTH  = 64;   // holds any counter value for clamping to a field
  localparam int PCT_WIDTH   = 14;   // width of the percent field
  localparam int QUEUE_DEPTH = 4;    // entries between the parser and the counters

  localparam logic [PCT_WIDTH-1:0] PCT_MAX = 14'd10000;

  // The percent is (gc * GC_SCALE + total) / (2 * total).
  localparam int SCALE_BITS = 15;
  localparam logic [SCALE_BITS-1:0] GC_SCALE = 15'd20000;

  // Byte classes handed from the parser to the counters.
  localparam logic [2:0] CLS_NONE = 3'd0;
  localparam logic [2:0] CLS_A    = 3'd1;
  localparam logic [2:0] CLS_C    = 3'd2;
  localparam logic [2:0] CLS_G    = 3'd3;
  localparam logic [2:0] CLS_T    = 3'd4;
  localparam logic [2:0] CLS_BAD  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic [PCT_WIDTH-1:0]   gc_hundredths;
    logic [FIELD_WIDTH-1:0] gc_total;
    logic [FIELD_WIDTH-1:0] at_total;
    logic                   no_bases;
    logic [FIELD_WIDTH-1:0] bad_byte_total;
  } result_t;

  typedef struct packed {
    logic       last;
    logic [2:0] cls;
  } entry_t;

endpackage

// ===== hw/rtl/gcc_front.sv =====
// ----------------------------------------------------------------------------
// gcc_front
// Tracks the header and sequence lines of the file and classifies each byte.
// ----------------------------------------------------------------------------
module gcc_front (
  input  logic           clk,
  input  logic           rst,
  input  gcc_pkg::item_t item,
  input  logic           accept,
  output gcc_pkg::entry_t entry,
  output logic           entry_push
);

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_SEQ    = 2'd2;

  localparam logic [7:0] CHAR_GT = 8'h3E;
  localparam logic [7:0] CHAR_NL = 8'h0A;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [2:0] cls;

  function automatic logic [2:0] classify(input logic [7:0] ch);
    logic [7:0] u;
    logic [2:0] c;
    u = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (u)
      "A": c = gcc_pkg::CLS_A;
      "C": c = gcc_pkg::CLS_C;
      "G": c = gcc_pkg::CLS_G;
      "T": c = gcc_pkg::CLS_T;
      "M", "R", "W", "S", "Y", "K", "V", "H", "D", "B", "X", "N": c = gcc_pkg::CLS_NONE;
      default: c = gcc_pkg::CLS_BAD;
    endcase
    return c;
  endfunction

  always_comb begin
    phase_next = phase;
    cls        = gcc_pkg::CLS_NONE;
    case (phase)
      PH_SKIP: begin
        phase_next = PH_HEADER;
      end
      PH_HEADER: begin
        if (item.data_byte == CHAR_NL) begin
          phase_next = PH_SEQ;
        end
      end
      default: begin
        phase_next = PH_SEQ;
        if (item.data_byte == CHAR_GT) begin
          phase_next = PH_HEADER;
        end else if (item.data_byte != CHAR_NL) begin
          cls = classify(item.data_byte);
        end
      end
    endcase
    // The next file starts over with its own first byte skipped.
    if (item.end_of_file) begin
      phase_next = PH_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SKIP;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  assign entry.last = item.end_of_file;
  assign entry.cls  = cls;
  assign entry_push = accept && (cls != gcc_pkg::CLS_NONE || item.end_of_file);

endmodule

// ===== hw/rtl/gcc_fifo.sv =====
// ----------------------------------------------------------------------------
// gcc_fifo
// Short queue of classified bytes between the parser and the counters.
// ----------------------------------------------------------------------------
module gcc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gcc_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output gcc_pkg::entry_t rdata,
  output logic            empty
);

  localparam int DEPTH = gcc_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  gcc_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/gcc_back.sv =====
// ----------------------------------------------------------------------------
// gcc_back
// Saturating base and bad-byte counters, and the end-of-file percent unit
// (shift-add multiply, then restoring division, one step per cycle).
// ----------------------------------------------------------------------------
module gcc_back #(
  parameter int COUNT_WIDTH = gcc_pkg::COUNT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  gcc_pkg::entry_t  entry,
  input  logic             entry_valid,
  output logic             entry_take,
  output gcc_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_take
);

  localparam int CW   = COUNT_WIDTH;
  localparam int NW   = CW + gcc_pkg::SCALE_BITS + 2;
  localparam int PW   = gcc_pkg::PCT_WIDTH;
  localparam int SB   = gcc_pkg::SCALE_BITS;
  localparam int FW   = gcc_pkg::FIELD_WIDTH;
  localparam int WIDE = gcc_pkg::WIDE_WIDTH;
  localparam int MBW  = $clog2(SB);
  localparam int DBW  = $clog2(PW);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_PREP1 = 3'd1;
  localparam logic [2:0] B_PREP2 = 3'd2;
  localparam logic [2:0] B_MUL   = 3'd3;
  localparam logic [2:0] B_DIV   = 3'd4;
  localparam logic [2:0] B_OUT   = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] cnt_a, cnt_c, cnt_g, cnt_t, cnt_bad;
  logic [CW:0]   gc_r, at_r;
  logic [CW+1:0] tot_r;
  logic [NW-1:0] num, gsh, dsh;
  logic [MBW-1:0] mbit;
  logic [DBW-1:0] dstep;
  logic [PW-1:0] quo;
  logic          out_load;
  logic          no_bases;

  function automatic logic [FW-1:0] sat_field(input logic [CW:0] v);
    logic [CW-1:0]   c;
    logic [WIDE-1:0] e;
    c = v[CW] ? '1 : v[CW-1:0];
    e = WIDE'(c);
    return (|e[WIDE-1:FW]) ? '1 : e[FW-1:0];
  endfunction

  assign entry_take = (state == B_IDLE) && entry_valid;
  assign out_load   = (state == B_OUT) && (!result_valid || result_take);
  assign no_bases   = (tot_r == '0);

  // Counters: one classified byte per cycle while idle, cleared with the result.
  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      cnt_a   <= '0;
      cnt_c   <= '0;
      cnt_g   <= '0;
      cnt_t   <= '0;
      cnt_bad <= '0;
    end else if (entry_take) begin
      case (entry.cls)
        gcc_pkg::CLS_A:   if (cnt_a != '1) cnt_a <= cnt_a + 1'b1;
        gcc_pkg::CLS_C:   if (cnt_c != '1) cnt_c <= cnt_c + 1'b1;
        gcc_pkg::CLS_G:   if (cnt_g != '1) cnt_g <= cnt_g + 1'b1;
        gcc_pkg::CLS_T:   if (cnt_t != '1) cnt_t <= cnt_t + 1'b1;
        gcc_pkg::CLS_BAD: if (cnt_bad != '1) cnt_bad <= cnt_bad + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (entry_take && entry.last) begin
            state <= B_PREP1;
          end
        end
        B_PREP1: state <= B_PREP2;
        B_PREP2: state <= B_MUL;
        B_MUL: begin
          if (mbit == MBW'(SB - 1)) begin
            state <= no_bases ? B_OUT : B_DIV;
          end
        end
        B_DIV: begin
          if (dstep == DBW'(PW - 1)) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_load) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Datapath of the percent unit.
  always_ff @(posedge clk) begin
    case (state)
      B_PREP1: begin
        gc_r <= {1'b0, cnt_g} + {1'b0, cnt_c};
        at_r <= {1'b0, cnt_a} + {1'b0, cnt_t};
      end
      B_PREP2: begin
        tot_r <= {1'b0, gc_r} + {1'b0, at_r};
        num   <= NW'({1'b0, gc_r} + {1'b0, at_r});
        gsh   <= NW'(gc_r);
        mbit  <= '0;
        quo   <= '0;
      end
      B_MUL: begin
        // The rounding term is already in num; add the scaled gc one bit at a time.
        if (gcc_pkg::GC_SCALE[mbit]) begin
          num <= num + gsh;
        end
        gsh   <= gsh << 1;
        mbit  <= mbit + 1'b1;
        dsh   <= NW'(tot_r) << PW;
        dstep <= '0;
      end
      B_DIV: begin
        if (num >= dsh) begin
          num <= num - dsh;
          quo <= {quo[PW-2:0], 1'b1};
        end else begin
          quo <= {quo[PW-2:0], 1'b0};
        end
        dsh   <= dsh >> 1;
        dstep <= dstep + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.gc_hundredths  <= (quo > gcc_pkg::PCT_MAX) ? gcc_pkg::PCT_MAX : quo;
      result.gc_total       <= sat_field(gc_r);
      result.at_total       <= sat_field(at_r);
      result.no_bases       <= no_bases;
      result.bad_byte_total <= sat_field({1'b0, cnt_bad});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (cnt_a == '0 && cnt_c == '0 && cnt_g == '0 && cnt_t == '0 && cnt_bad == '0))
    else $error("counters not cleared after a result request was loaded");

  a_counts_hold: assert property (@(posedge clk) disable iff (rst)
    (state == B_MUL || state == B_DIV) |=> $stable({cnt_a, cnt_c, cnt_g, cnt_t, cnt_bad}))
    else $error("counters changed while the percent was being computed");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.gc_hundredths <= gcc_pkg::PCT_MAX)
    else $error("percent above 100.00");

  a_no_bases: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.no_bases) |->
      (result.gc_hundredths == '0 && result.gc_total == '0 && result.at_total == '0))
    else $error("no-bases result carries nonzero counts or percent");

endmodule

// ===== hw/rtl/fasta_gc_content_counter.sv =====
// ----------------------------------------------------------------------------
// fasta_gc_content_counter
// Counts A/C/G/T and bad bytes of a FASTA byte stream and reports GC content.
// ----------------------------------------------------------------------------
// One byte request is taken per cycle while full is low. A parser classifies
// each byte and places counted bytes and the end-of-file mark into a
// four-entry queue; the counting unit drains that queue at one entry per
// cycle while idle. At the end of a file the counting unit forms the result:
// setup states that sum the counts, a shift-add multiply by 20000, a
// restoring division, one step per cycle, and a load of the output register
// once it is free. A file with no bases skips the division. During that time
// the parser keeps accepting bytes of the next file until the queue fills.
// The result then waits in an output register until it is popped, and the
// counters start from zero for the next file.
module fasta_gc_content_counter #(
  parameter int COUNT_WIDTH = gcc_pkg::COUNT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  gcc_pkg::item_t   item,
  input  logic             push,
  output logic             full,
  output gcc_pkg::result_t result,
  output logic             empty,
  input  logic             pop
);

  gcc_pkg::entry_t front_entry;
  gcc_pkg::entry_t queue_entry;
  logic            front_push;
  logic            queue_empty;
  logic            queue_take;
  logic            result_valid;
  logic            accept;

  assign accept = push && !full;
  assign empty  = !result_valid;

  gcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .accept     (accept),
    .entry      (front_entry),
    .entry_push (front_push)
  );

  gcc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_entry),
    .full  (full),
    .pop   (queue_take),
    .rdata (queue_entry),
    .empty (queue_empty)
  );

  gcc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .entry        (queue_entry),
    .entry_valid  (!queue_empty),
    .entry_take   (queue_take),
    .result       (result),
    .result_valid (result_valid),
    .result_take  (pop)
  );

endmodule
